// ----- rtl/core/epc_pkg.sv -----
// Shared types and constants for the ethertype / MAC priority classifier.
`default_nettype none

package epc_pkg;

  localparam int TYPE_ENTRIES_DEF = 8;
  localparam int MAC_ENTRIES_DEF  = 8;

  localparam logic [15:0] LENGTH_LIMIT = 16'h0600;
  localparam logic [15:0] VLAN_TPID    = 16'h8100;

  typedef enum logic [2:0] {
    OP_CLASSIFY = 3'd0,
    OP_ADD_TYPE = 3'd1,
    OP_DEL_TYPE = 3'd2,
    OP_ADD_MAC  = 3'd3,
    OP_DEL_MAC  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_FETCH,
    S_MOVE
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [47:0] dest_mac;
    logic [15:0] outer_type;
    logic [15:0] inner_type;
  } in_t;

  typedef struct packed {
    logic       is_priority;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic fetch;
    logic append;
    logic move;
    logic finish;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic scan_last;
    logic type_found;
    logic mac_found;
    logic type_full;
    logic mac_full;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ether_priority_classifier.sv -----
// Top level of the ethertype / destination MAC priority classifier.
`default_nettype none

// Command port: an item is taken on a clock edge with start high and busy low.
// item.operation selects classify, add/remove ethertype or add/remove MAC.
// Each accepted beat yields exactly one result on the result port, flagged by
// done for a single cycle; the receiver cannot stall it.
// Both tables are scanned together, one entry per cycle, through a
// registered-read memory per table, over D entries with D the larger of
// TYPE_ENTRIES and MAC_ENTRIES. A remove that hits then reads the last entry
// and writes it into the hole before done rises.
// busy drops in the cycle done is high, so a new beat may be taken then;
// no new item is taken while one is in progress.
// Reset clears both entry counts, so both tables read as empty; table
// contents are not cleared and no entry at or above a count is used.
// Classify reports is_priority; add reports full when the entry is new and
// the table is out of room; remove ethertype reports not found on a miss.
module ether_priority_classifier #(
  parameter int TYPE_ENTRIES = epc_pkg::TYPE_ENTRIES_DEF,
  parameter int MAC_ENTRIES  = epc_pkg::MAC_ENTRIES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire epc_pkg::in_t item,
  output logic              done,
  output epc_pkg::out_t     result
);

  epc_pkg::cmd_t  cmd;
  epc_pkg::stat_t stat;

  epc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  epc_dp #(
    .TYPE_ENTRIES (TYPE_ENTRIES),
    .MAC_ENTRIES  (MAC_ENTRIES)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

`default_nettype wire

// ----- rtl/core/epc_ctrl.sv -----
// Sequencer for the classifier: scan, decide, and move-last-into-hole.
`default_nettype none

module epc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire epc_pkg::stat_t stat,
  output epc_pkg::cmd_t       cmd
);

  epc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= epc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != epc_pkg::S_IDLE);
    unique case (state)
      epc_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = epc_pkg::S_SCAN;
        end
      end
      epc_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = epc_pkg::S_DRAIN;
        end
      end
      epc_pkg::S_DRAIN: begin
        state_next = epc_pkg::S_DECIDE;
      end
      epc_pkg::S_DECIDE: begin
        state_next = epc_pkg::S_IDLE;
        cmd.finish = 1'b1;
        unique case (stat.op)
          epc_pkg::OP_ADD_TYPE: begin
            cmd.append = !stat.type_found && !stat.type_full;
          end
          epc_pkg::OP_ADD_MAC: begin
            cmd.append = !stat.mac_found && !stat.mac_full;
          end
          epc_pkg::OP_DEL_TYPE: begin
            if (stat.type_found) begin
              cmd.finish = 1'b0;
              state_next = epc_pkg::S_FETCH;
            end
          end
          epc_pkg::OP_DEL_MAC: begin
            if (stat.mac_found) begin
              cmd.finish = 1'b0;
              state_next = epc_pkg::S_FETCH;
            end
          end
          default: begin
          end
        endcase
      end
      epc_pkg::S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = epc_pkg::S_MOVE;
      end
      epc_pkg::S_MOVE: begin
        cmd.move   = 1'b1;
        cmd.finish = 1'b1;
        state_next = epc_pkg::S_IDLE;
      end
      default: begin
        state_next = epc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/epc_dp.sv -----
// Datapath: both match tables, counts, scan compare and result register.
`default_nettype none

module epc_dp #(
  parameter int TYPE_ENTRIES = epc_pkg::TYPE_ENTRIES_DEF,
  parameter int MAC_ENTRIES  = epc_pkg::MAC_ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire epc_pkg::in_t  item,
  input  wire epc_pkg::cmd_t cmd,
  output epc_pkg::stat_t     stat,
  output logic               done,
  output epc_pkg::out_t      result
);

  localparam int SCAN_DEPTH = (TYPE_ENTRIES > MAC_ENTRIES) ? TYPE_ENTRIES : MAC_ENTRIES;
  localparam int SW   = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1;
  localparam int TAW  = (TYPE_ENTRIES > 1) ? $clog2(TYPE_ENTRIES) : 1;
  localparam int MAW  = (MAC_ENTRIES > 1) ? $clog2(MAC_ENTRIES) : 1;
  localparam int TCW  = $clog2(TYPE_ENTRIES + 1);
  localparam int MCW  = $clog2(MAC_ENTRIES + 1);
  localparam int CMPW = $clog2(SCAN_DEPTH + 1) + 1;

  logic [15:0] type_mem [TYPE_ENTRIES];
  logic [47:0] mac_mem  [MAC_ENTRIES];

  epc_pkg::op_t op;
  logic [47:0]  mac;
  logic [15:0]  outer;
  logic [15:0]  inner;

  logic [TCW-1:0] type_count;
  logic [MCW-1:0] mac_count;
  logic [SW-1:0]  cnt;
  logic           rd_valid;
  logic [SW-1:0]  rd_idx;
  logic [15:0]    type_rd;
  logic [47:0]    mac_rd;
  logic           type_found;
  logic           mac_found;
  logic [SW-1:0]  type_idx;
  logic [SW-1:0]  mac_idx;

  logic [15:0]    type_key;
  logic           type_hit;
  logic           mac_hit;
  logic [TCW-1:0] type_last;
  logic [MCW-1:0] mac_last;
  logic [TAW-1:0] type_ra;
  logic [MAW-1:0] mac_ra;
  logic           type_we;
  logic           mac_we;
  logic [TAW-1:0] type_wa;
  logic [MAW-1:0] mac_wa;
  logic [15:0]    type_wd;
  logic [47:0]    mac_wd;
  logic           type_full;
  logic           mac_full;
  epc_pkg::out_t  res_next;

  assign type_key  = (op == epc_pkg::OP_CLASSIFY && outer == epc_pkg::VLAN_TPID) ? inner : outer;
  assign type_hit  = rd_valid && (CMPW'(rd_idx) < CMPW'(type_count)) && (type_rd == type_key);
  assign mac_hit   = rd_valid && (CMPW'(rd_idx) < CMPW'(mac_count)) && (mac_rd == mac);
  assign type_last = type_count - TCW'(1);
  assign mac_last  = mac_count - MCW'(1);
  assign type_full = (type_count == TCW'(TYPE_ENTRIES));
  assign mac_full  = (mac_count == MCW'(MAC_ENTRIES));

  assign type_ra = cmd.fetch ? type_last[TAW-1:0] : cnt[TAW-1:0];
  assign mac_ra  = cmd.fetch ? mac_last[MAW-1:0] : cnt[MAW-1:0];

  assign type_we = (cmd.append && op == epc_pkg::OP_ADD_TYPE) ||
                   (cmd.move && op == epc_pkg::OP_DEL_TYPE);
  assign mac_we  = (cmd.append && op == epc_pkg::OP_ADD_MAC) ||
                   (cmd.move && op == epc_pkg::OP_DEL_MAC);
  assign type_wa = cmd.move ? type_idx[TAW-1:0] : type_count[TAW-1:0];
  assign mac_wa  = cmd.move ? mac_idx[MAW-1:0] : mac_count[MAW-1:0];
  assign type_wd = cmd.move ? type_rd : outer;
  assign mac_wd  = cmd.move ? mac_rd : mac;

  always_ff @(posedge clk) begin
    if (type_we) begin
      type_mem[type_wa] <= type_wd;
    end
    type_rd <= type_mem[type_ra];
  end

  always_ff @(posedge clk) begin
    if (mac_we) begin
      mac_mem[mac_wa] <= mac_wd;
    end
    mac_rd <= mac_mem[mac_ra];
  end

  // item capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= epc_pkg::op_t'(item.operation);
      mac        <= item.dest_mac;
      outer      <= item.outer_type;
      inner      <= item.inner_type;
      cnt        <= '0;
      type_found <= 1'b0;
      mac_found  <= 1'b0;
    end else begin
      if (cmd.scan) begin
        cnt <= cnt + SW'(1);
      end
      if (type_hit && !type_found) begin
        type_found <= 1'b1;
        type_idx   <= rd_idx;
      end
      if (mac_hit && !mac_found) begin
        mac_found <= 1'b1;
        mac_idx   <= rd_idx;
      end
    end
    rd_idx <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      type_count <= '0;
      mac_count  <= '0;
      done       <= 1'b0;
    end else begin
      rd_valid <= cmd.scan;
      done     <= cmd.finish;
      if (type_we) begin
        type_count <= cmd.move ? type_count - TCW'(1) : type_count + TCW'(1);
      end
      if (mac_we) begin
        mac_count <= cmd.move ? mac_count - MCW'(1) : mac_count + MCW'(1);
      end
    end
  end

  always_comb begin
    res_next = '0;
    unique case (op)
      epc_pkg::OP_CLASSIFY: begin
        res_next.is_priority = (outer >= epc_pkg::LENGTH_LIMIT && type_found) || mac_found;
      end
      epc_pkg::OP_ADD_TYPE: begin
        if (!type_found && type_full) begin
          res_next.status = epc_pkg::ST_FULL;
        end
      end
      epc_pkg::OP_ADD_MAC: begin
        if (!mac_found && mac_full) begin
          res_next.status = epc_pkg::ST_FULL;
        end
      end
      epc_pkg::OP_DEL_TYPE: begin
        if (!type_found) begin
          res_next.status = epc_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result <= res_next;
    end
  end

  always_comb begin
    stat            = '0;
    stat.op         = op;
    stat.scan_last  = (cnt == SW'(SCAN_DEPTH - 1));
    stat.type_found = type_found;
    stat.mac_found  = mac_found;
    stat.type_full  = type_full;
    stat.mac_full   = mac_full;
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_type_bound: assert property (@(posedge clk) disable iff (rst)
    CMPW'(type_count) <= CMPW'(TYPE_ENTRIES))
    else $error("type count above table depth");

  a_mac_bound: assert property (@(posedge clk) disable iff (rst)
    CMPW'(mac_count) <= CMPW'(MAC_ENTRIES))
    else $error("mac count above table depth");

  a_move_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.move |-> ((op == epc_pkg::OP_DEL_TYPE && type_found) ||
                  (op == epc_pkg::OP_DEL_MAC && mac_found)))
    else $error("entry move without a matching entry");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> ((op == epc_pkg::OP_ADD_TYPE && !type_full) ||
                    (op == epc_pkg::OP_ADD_MAC && !mac_full)))
    else $error("append into a full table");

endmodule

`default_nettype wire

// ----- bench/tb_ether_priority_classifier.sv -----
// Self-checking bench for the ethertype / destination MAC priority classifier.
`default_nettype none

module tb_ether_priority_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import epc_pkg::*;

  localparam int N_TYPES = TYPE_ENTRIES_DEF;
  localparam int N_MACS  = MAC_ENTRIES_DEF;
  localparam int POOL    = 12;

  typedef struct {
    in_t  cmd;
    out_t res;
  } verdict_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_t  item;
  logic done;
  out_t result;

  ether_priority_classifier DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  // shadow copy of both match tables
  logic [15:0] prio_types [N_TYPES];
  int          type_cnt;
  logic [47:0] prio_macs [N_MACS];
  int          mac_cnt;

  verdict_t    pending_verdicts[$];
  int          err_cnt;
  logic [15:0] type_pool [POOL];
  logic [47:0] mac_pool [POOL];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int find_type(input logic [15:0] t);
    for (int i = 0; i < type_cnt; i++)
      if (prio_types[i] == t) return i;
    return -1;
  endfunction

  function automatic int find_mac(input logic [47:0] m);
    for (int i = 0; i < mac_cnt; i++)
      if (prio_macs[i] == m) return i;
    return -1;
  endfunction

  // expected result of one beat; updates the shadow tables
  function automatic out_t classify_and_update(input in_t cmd);
    out_t        r;
    int          idx;
    logic [15:0] t;
    r.is_priority = 1'b0;
    r.status      = ST_OK;
    case (cmd.operation)
      OP_CLASSIFY: begin
        if (type_cnt != 0 && cmd.outer_type >= LENGTH_LIMIT) begin
          t = (cmd.outer_type == VLAN_TPID) ? cmd.inner_type : cmd.outer_type;
          if (find_type(t) >= 0) r.is_priority = 1'b1;
        end
        if (mac_cnt != 0 && find_mac(cmd.dest_mac) >= 0) r.is_priority = 1'b1;
      end
      OP_ADD_TYPE: begin
        if (find_type(cmd.outer_type) < 0) begin
          if (type_cnt >= N_TYPES) begin
            r.status = ST_FULL;
          end else begin
            prio_types[type_cnt] = cmd.outer_type;
            type_cnt++;
          end
        end
      end
      OP_DEL_TYPE: begin
        idx = find_type(cmd.outer_type);
        if (idx < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          prio_types[idx] = prio_types[type_cnt-1];
          type_cnt--;
        end
      end
      OP_ADD_MAC: begin
        if (find_mac(cmd.dest_mac) < 0) begin
          if (mac_cnt >= N_MACS) begin
            r.status = ST_FULL;
          end else begin
            prio_macs[mac_cnt] = cmd.dest_mac;
            mac_cnt++;
          end
        end
      end
      OP_DEL_MAC: begin
        idx = find_mac(cmd.dest_mac);
        if (idx >= 0) begin
          prio_macs[idx] = prio_macs[mac_cnt-1];
          mac_cnt--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_t mk(input logic [2:0] op, input logic [47:0] mac,
                             input logic [15:0] outer, input logic [15:0] inner);
    in_t c;
    c.operation  = op;
    c.dest_mac   = mac;
    c.outer_type = outer;
    c.inner_type = inner;
    return c;
  endfunction

  function automatic logic [47:0] rand_mac();
    return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom())};
  endfunction

  task automatic send_beat(input in_t cmd);
    verdict_t v;
    start <= 1'b1;
    item  <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    v.cmd = cmd;
    v.res = classify_and_update(cmd);
    pending_verdicts.push_back(v);
  endtask

  task automatic idle_gap(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic note_error(input string msg);
    if (err_cnt < 10) $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // result checker
  always @(posedge clk) begin
    verdict_t v;
    if (!rst && done) begin
      if (pending_verdicts.size() == 0) begin
        note_error($sformatf("unexpected result prio=%b status=%0d",
                             result.is_priority, result.status));
      end else begin
        v = pending_verdicts.pop_front();
        if (result.is_priority !== v.res.is_priority)
          note_error($sformatf("op %0d mac %h type %h/%h: is_priority exp %b got %b",
                               v.cmd.operation, v.cmd.dest_mac, v.cmd.outer_type,
                               v.cmd.inner_type, v.res.is_priority, result.is_priority));
        if (result.status !== v.res.status)
          note_error($sformatf("op %0d mac %h type %h/%h: status exp %0d got %0d",
                               v.cmd.operation, v.cmd.dest_mac, v.cmd.outer_type,
                               v.cmd.inner_type, v.res.status, result.status));
      end
    end
  end

  task automatic test_type_table();
    send_beat(mk(OP_ADD_TYPE, '0, 16'h0000, '0));
    send_beat(mk(OP_ADD_TYPE, '0, 16'hFFFF, '0));
    send_beat(mk(OP_ADD_TYPE, '0, 16'hFFFF, '0));
    send_beat(mk(OP_ADD_TYPE, '0, 16'h0800, '0));
    send_beat(mk(OP_ADD_TYPE, '0, 16'h86DD, '0));
    send_beat(mk(OP_ADD_TYPE, '0, 16'h88F7, '0));
    send_beat(mk(OP_ADD_TYPE, '0, 16'h0806, '0));
    send_beat(mk(OP_ADD_TYPE, '0, 16'h88CC, '0));
    send_beat(mk(OP_ADD_TYPE, '0, 16'h8809, '0));
    send_beat(mk(OP_ADD_TYPE, '0, 16'h1234, '0));
    send_beat(mk(OP_ADD_TYPE, '0, 16'h0800, '0));
    send_beat(mk(OP_DEL_TYPE, '0, 16'h5555, '0));
  endtask

  task automatic test_classify_cases();
    send_beat(mk(OP_CLASSIFY, 48'h0000_0000_0001, 16'h0800, 16'h0000));
    send_beat(mk(OP_CLASSIFY, 48'h0000_0000_0001, VLAN_TPID, 16'hFFFF));
    send_beat(mk(OP_CLASSIFY, 48'h0000_0000_0001, 16'h05FF, 16'h0800));
    send_beat(mk(OP_CLASSIFY, 48'h0000_0000_0001, 16'h0600, 16'h0800));
    send_beat(mk(OP_DEL_TYPE, '0, 16'h0000, '0));
  endtask

  task automatic test_mac_table();
    send_beat(mk(OP_ADD_MAC, 48'h0, '0, '0));
    send_beat(mk(OP_ADD_MAC, 48'hFFFF_FFFF_FFFF, '0, '0));
    send_beat(mk(OP_DEL_MAC, 48'h0123_4567_89AB, '0, '0));
    send_beat(mk(OP_CLASSIFY, 48'hFFFF_FFFF_FFFF, 16'h0000, 16'h0000));
    send_beat(mk(OP_DEL_MAC, 48'h0, '0, '0));
  endtask

  task automatic test_unused_ops();
    send_beat(mk(3'd5, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF));
    send_beat(mk(3'd7, 48'h0, 16'h0800, 16'h0000));
  endtask

  function automatic in_t rand_item();
    in_t c;
    int  sel;
    c   = mk('0, rand_mac(), 16'($urandom_range(0, 16'hFFFF)),
             16'($urandom_range(0, 16'hFFFF)));
    sel = $urandom_range(0, 99);
    if (sel < 40)      c.operation = OP_CLASSIFY;
    else if (sel < 54) c.operation = OP_ADD_TYPE;
    else if (sel < 68) c.operation = OP_DEL_TYPE;
    else if (sel < 82) c.operation = OP_ADD_MAC;
    else if (sel < 96) c.operation = OP_DEL_MAC;
    else               c.operation = 3'($urandom_range(5, 7));
    // mostly pool values so adds, removes and matches hit each other
    if ($urandom_range(0, 4) != 0) c.dest_mac = mac_pool[$urandom_range(0, POOL-1)];
    if ($urandom_range(0, 4) != 0) c.outer_type = type_pool[$urandom_range(0, POOL-1)];
    if ($urandom_range(0, 3) != 0) c.inner_type = type_pool[$urandom_range(0, POOL-1)];
    if (c.operation == OP_CLASSIFY) begin
      case ($urandom_range(0, 5))
        0: c.outer_type = VLAN_TPID;
        1: c.outer_type = 16'($urandom_range(0, 16'h05FF));
        2: c.outer_type = 16'($urandom_range(16'h05FE, 16'h0601));
        default: ;
      endcase
    end
    return c;
  endfunction

  task automatic test_random_mixed(input int n);
    for (int i = 0; i < POOL; i++) begin
      type_pool[i] = (i < 4) ? 16'($urandom_range(0, 16'h05FF))
                             : 16'($urandom_range(16'h0600, 16'hFFFF));
      mac_pool[i]  = rand_mac();
    end
    type_pool[POOL-1] = VLAN_TPID;
    for (int i = 0; i < n; i++) begin
      send_beat(rand_item());
      if ((i / 40) % 3 != 2 && $urandom_range(0, 2) == 0)
        idle_gap($urandom_range(1, 5));
    end
  endtask

  task automatic test_random_steady(input int n);
    for (int i = 0; i < n; i++) send_beat(rand_item());
    start <= 1'b0;
  endtask

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    item    = '0;
    err_cnt = 0;
    type_cnt = 0;
    mac_cnt  = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_type_table();
    test_classify_cases();
    test_mac_table();
    test_unused_ops();
    test_random_mixed(800);
    test_random_steady(200);

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && pending_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_verdicts.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
